FILE: rtl/double_to_decimal_text_assert.svh
// assertion macros shared by the rtl
`ifndef DOUBLE_TO_DECIMAL_TEXT_ASSERT_SVH
`define DOUBLE_TO_DECIMAL_TEXT_ASSERT_SVH
`ifndef SYNTHESIS
`define D2DT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define D2DT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define D2DT_ASSERT(label, prop, msg)
`define D2DT_NEVER(label, cond, msg)
`endif
`endif

FILE: rtl/d2dt_pkg.sv
package d2dt_pkg;

   localparam int MANT_BITS   = 53;
   localparam int INT_BITS    = 63;
   localparam int INT_DIGITS  = 19;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [10:0] EXP_ALL_ONES = 11'h7ff;
   localparam logic [10:0] EXP_LIMIT    = 11'd1086;
   localparam logic [10:0] EXP_INT_ONLY = 11'd1075;
   localparam logic [10:0] SHIFT_SUBNORM = 11'd1074;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_DOT   = 8'h2e;
   localparam logic [7:0] CHAR_NONE  = 8'h00;

   typedef struct packed {
      logic                  err;
      logic                  neg;
      logic [INT_BITS-1:0]   ip;
      logic [MANT_BITS-1:0]  frac;
      logic [10:0]           shift;
   } item_type;

endpackage

FILE: rtl/d2dt_front.sv
module d2dt_front (
   input  logic                 push,
   input  logic [63:0]          value_bits,
   input  logic                 q_full,
   output logic                 q_push,
   output d2dt_pkg::item_type   q_item
);

   logic [10:0] expo;
   logic [51:0] mant;
   logic [52:0] m;
   logic [10:0] sh;
   logic [52:0] mask;

   always_comb begin
      expo = value_bits[62:52];
      mant = value_bits[51:0];
      m    = (expo == 11'd0) ? {1'b0, mant} : {1'b1, mant};
      sh   = 11'd0;
      mask = '0;
      q_item.err = (expo == d2dt_pkg::EXP_ALL_ONES) || (expo >= d2dt_pkg::EXP_LIMIT);
      q_item.neg = value_bits[63] && (value_bits[62:0] != 63'd0);
      q_item.ip    = '0;
      q_item.frac  = '0;
      q_item.shift = 11'd1;
      if (expo == 11'd0) begin
         q_item.frac  = m;
         q_item.shift = d2dt_pkg::SHIFT_SUBNORM;
      end else if (expo > d2dt_pkg::EXP_INT_ONLY) begin
         // integer only, shift left by at most ten
         sh = expo - d2dt_pkg::EXP_INT_ONLY;
         q_item.ip = {10'd0, m} << sh[3:0];
      end else begin
         sh = d2dt_pkg::EXP_INT_ONLY - expo;
         q_item.shift = sh;
         if (sh >= 11'd53) begin
            q_item.frac = m;
         end else begin
            mask = ~(53'h1f_ffff_ffff_ffff << sh[5:0]);
            q_item.ip   = {10'd0, m >> sh[5:0]};
            q_item.frac = m & mask;
         end
      end
   end

   assign q_push = push && !q_full;

endmodule

FILE: rtl/d2dt_queue.sv
`include "double_to_decimal_text_assert.svh"

module d2dt_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  d2dt_pkg::item_type   item_in,
   output logic                 full,
   input  logic                 pop,
   output d2dt_pkg::item_type   item_out,
   output logic                 empty
);

   d2dt_pkg::item_type mem_ff [d2dt_pkg::QUEUE_DEPTH];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full     = (count_ff == 2'(d2dt_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == 2'd0);
   assign item_out = mem_ff[rd_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_in    = do_push ? ~wr_ff : wr_ff;
      rd_in    = do_pop ? ~rd_ff : rd_ff;
      count_in = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= item_in;
      end
   end

   `D2DT_NEVER(a_q_count, count_ff > 2'(d2dt_pkg::QUEUE_DEPTH), "queue count overflow")
   `D2DT_ASSERT(a_q_ptr, empty || full |-> wr_ff == rd_ff, "queue pointer mismatch")

endmodule

FILE: rtl/d2dt_back.sv
`include "double_to_decimal_text_assert.svh"

module d2dt_back #(
   parameter int FRAC_DIGITS = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  d2dt_pkg::item_type   q_item,
   output logic                 q_pop,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [7:0]           rsp_char_code,
   output logic                 rsp_is_last,
   output logic                 rsp_out_of_range
);

   localparam int TW  = $clog2(10**FRAC_DIGITS);
   localparam int PW  = d2dt_pkg::MANT_BITS + TW;
   localparam int FW  = 4 * FRAC_DIGITS;
   localparam int IW  = 4 * d2dt_pkg::INT_DIGITS;
   localparam int FIW = (FRAC_DIGITS > 1) ? $clog2(FRAC_DIGITS) : 1;
   localparam logic [53:0] T54 = 54'(10**FRAC_DIGITS);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_CONV = 3'd1;
   localparam logic [2:0] ST_SIGN = 3'd2;
   localparam logic [2:0] ST_SKIP = 3'd3;
   localparam logic [2:0] ST_INT  = 3'd4;
   localparam logic [2:0] ST_DOT  = 3'd5;
   localparam logic [2:0] ST_FRAC = 3'd6;
   localparam logic [2:0] ST_ERR  = 3'd7;

   localparam logic [2:0] F_MUL  = 3'd0;
   localparam logic [2:0] F_NORM = 3'd1;
   localparam logic [2:0] F_RND  = 3'd2;
   localparam logic [2:0] F_DAB  = 3'd3;
   localparam logic [2:0] F_DONE = 3'd4;

   function automatic logic [3:0] dd_adj(input logic [3:0] d);
      return (d >= 4'd5) ? d + 4'd3 : d;
   endfunction

   logic [2:0]   state_ff, state_in;
   logic [2:0]   fph_ff, fph_in;
   logic         neg_ff, neg_in;
   logic [62:0]  ip_ff, ip_in;
   logic [IW-1:0] ibcd_ff, ibcd_in;
   logic [5:0]   icnt_ff, icnt_in;
   logic [PW-1:0] p_ff, p_in;
   logic [3:0]   mcnt_ff, mcnt_in;
   logic [5:0]   k_ff, k_in;
   logic         guard_ff, guard_in;
   logic         sticky_ff, sticky_in;
   logic [10:0]  s_ff, s_in;
   logic [TW-1:0] fbin_ff, fbin_in;
   logic [FW-1:0] fbcd_ff, fbcd_in;
   logic [4:0]   fcnt_ff, fcnt_in;
   logic [4:0]   didx_ff, didx_in;
   logic [FIW-1:0] fidx_ff, fidx_in;
   logic         ov_ff, ov_in;
   logic [7:0]   oc_ff, oc_in;
   logic         ol_ff, ol_in;
   logic         oe_ff, oe_in;

   logic          room;
   logic [IW-1:0] iadj;
   logic [FW-1:0] fadj;
   logic [53:0]   q;
   logic [10:0]   net;
   logic [53:0]   fpv;
   logic [3:0]    idig;
   logic [3:0]    fdig;

   assign room = !ov_ff || rsp_pop;
   assign idig = ibcd_ff[didx_ff*4 +: 4];
   assign fdig = fbcd_ff[fidx_ff*4 +: 4];

   always_comb begin
      for (int i = 0; i < d2dt_pkg::INT_DIGITS; i++) begin
         iadj[i*4 +: 4] = dd_adj(ibcd_ff[i*4 +: 4]);
      end
      for (int i = 0; i < FRAC_DIGITS; i++) begin
         fadj[i*4 +: 4] = dd_adj(fbcd_ff[i*4 +: 4]);
      end
      // round to 53 significant bits, ties to even, then drop the binary point
      q   = {1'b0, p_ff[52:0]} + 54'(guard_ff && (sticky_ff || p_ff[0]));
      net = s_ff - {5'd0, k_ff};
      fpv = (net >= 11'd54) ? 54'd0 : (q >> net[5:0]);
      if (fpv >= T54) begin
         fpv = T54 - 54'd1;
      end
   end

   always_comb begin
      state_in  = state_ff;
      fph_in    = fph_ff;
      neg_in    = neg_ff;
      ip_in     = ip_ff;
      ibcd_in   = ibcd_ff;
      icnt_in   = icnt_ff;
      p_in      = p_ff;
      mcnt_in   = mcnt_ff;
      k_in      = k_ff;
      guard_in  = guard_ff;
      sticky_in = sticky_ff;
      s_in      = s_ff;
      fbin_in   = fbin_ff;
      fbcd_in   = fbcd_ff;
      fcnt_in   = fcnt_ff;
      didx_in   = didx_ff;
      fidx_in   = fidx_ff;
      q_pop     = 1'b0;
      ov_in     = rsp_pop ? 1'b0 : ov_ff;
      oc_in     = oc_ff;
      ol_in     = ol_ff;
      oe_in     = oe_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop     = 1'b1;
               neg_in    = q_item.neg;
               ip_in     = q_item.ip;
               ibcd_in   = '0;
               icnt_in   = 6'd0;
               p_in      = PW'(q_item.frac);
               mcnt_in   = 4'd0;
               k_in      = 6'd0;
               guard_in  = 1'b0;
               sticky_in = 1'b0;
               s_in      = q_item.shift;
               fph_in    = F_MUL;
               state_in  = q_item.err ? ST_ERR : ST_CONV;
            end
         end
         ST_CONV: begin
            if (icnt_ff != 6'(d2dt_pkg::INT_BITS)) begin
               ibcd_in = {iadj[IW-2:0], ip_ff[62]};
               ip_in   = {ip_ff[61:0], 1'b0};
               icnt_in = icnt_ff + 6'd1;
            end
            unique case (fph_ff)
               F_MUL: begin
                  if (mcnt_ff != 4'(FRAC_DIGITS)) begin
                     p_in    = (p_ff << 3) + (p_ff << 1);
                     mcnt_in = mcnt_ff + 4'd1;
                  end else begin
                     fph_in = F_NORM;
                  end
               end
               F_NORM: begin
                  if (p_ff[PW-1:53] != '0) begin
                     sticky_in = sticky_ff || guard_ff;
                     guard_in  = p_ff[0];
                     p_in      = p_ff >> 1;
                     k_in      = k_ff + 6'd1;
                  end else begin
                     fph_in = F_RND;
                  end
               end
               F_RND: begin
                  fbin_in = fpv[TW-1:0];
                  fbcd_in = '0;
                  fcnt_in = 5'd0;
                  fph_in  = F_DAB;
               end
               F_DAB: begin
                  if (fcnt_ff != 5'(TW)) begin
                     fbcd_in = {fadj[FW-2:0], fbin_ff[TW-1]};
                     fbin_in = fbin_ff << 1;
                     fcnt_in = fcnt_ff + 5'd1;
                  end else begin
                     fph_in = F_DONE;
                  end
               end
               default: begin
               end
            endcase
            if ((icnt_ff == 6'(d2dt_pkg::INT_BITS)) && (fph_ff == F_DONE)) begin
               didx_in  = 5'(d2dt_pkg::INT_DIGITS - 1);
               state_in = neg_ff ? ST_SIGN : ST_SKIP;
            end
         end
         ST_SIGN: begin
            if (room) begin
               ov_in = 1'b1; oc_in = d2dt_pkg::CHAR_MINUS; ol_in = 1'b0; oe_in = 1'b0;
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // drop leading zeros, keep at least one digit
            if ((idig == 4'd0) && (didx_ff != 5'd0)) begin
               didx_in = didx_ff - 5'd1;
            end else begin
               state_in = ST_INT;
            end
         end
         ST_INT: begin
            if (room) begin
               ov_in = 1'b1; oc_in = d2dt_pkg::CHAR_ZERO + {4'd0, idig};
               ol_in = 1'b0; oe_in = 1'b0;
               if (didx_ff == 5'd0) begin
                  state_in = ST_DOT;
               end else begin
                  didx_in = didx_ff - 5'd1;
               end
            end
         end
         ST_DOT: begin
            if (room) begin
               ov_in = 1'b1; oc_in = d2dt_pkg::CHAR_DOT; ol_in = 1'b0; oe_in = 1'b0;
               fidx_in  = FIW'(FRAC_DIGITS - 1);
               state_in = ST_FRAC;
            end
         end
         ST_FRAC: begin
            if (room) begin
               ov_in = 1'b1; oc_in = d2dt_pkg::CHAR_ZERO + {4'd0, fdig};
               ol_in = (fidx_ff == '0); oe_in = 1'b0;
               if (fidx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  fidx_in = fidx_ff - FIW'(1);
               end
            end
         end
         ST_ERR: begin
            if (room) begin
               ov_in = 1'b1; oc_in = d2dt_pkg::CHAR_NONE; ol_in = 1'b1; oe_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fph_ff   <= F_DONE;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         fph_ff   <= fph_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff    <= neg_in;
      ip_ff     <= ip_in;
      ibcd_ff   <= ibcd_in;
      icnt_ff   <= icnt_in;
      p_ff      <= p_in;
      mcnt_ff   <= mcnt_in;
      k_ff      <= k_in;
      guard_ff  <= guard_in;
      sticky_ff <= sticky_in;
      s_ff      <= s_in;
      fbin_ff   <= fbin_in;
      fbcd_ff   <= fbcd_in;
      fcnt_ff   <= fcnt_in;
      didx_ff   <= didx_in;
      fidx_ff   <= fidx_in;
      oc_ff     <= oc_in;
      ol_ff     <= ol_in;
      oe_ff     <= oe_in;
   end

   assign rsp_empty        = !ov_ff;
   assign rsp_char_code    = oc_ff;
   assign rsp_is_last      = ol_ff;
   assign rsp_out_of_range = oe_ff;

   `D2DT_ASSERT(a_err_last, ov_ff && oe_ff |-> ol_ff, "error beat not marked last")
   `D2DT_ASSERT(a_frac_idx, state_ff == ST_FRAC |-> fidx_ff < FIW'(FRAC_DIGITS), "fraction index out of range")
   `D2DT_ASSERT(a_int_idx, state_ff == ST_INT |-> didx_ff < 5'(d2dt_pkg::INT_DIGITS), "digit index out of range")
   `D2DT_ASSERT(a_pop_idle, q_pop |-> state_ff == ST_IDLE && !q_empty, "queue popped while busy")

endmodule

FILE: rtl/double_to_decimal_text.sv
// Formats an IEEE binary64 bit pattern as fixed-point decimal ASCII text.
// Input channel: req_push/req_full with req_value_bits; a beat is taken when
// req_push is high and req_full is low. A two-entry queue sits behind the
// front classifier, so up to two numbers can wait while one is converted.
// Result channel: one character per beat on rsp_char_code, valid while
// rsp_empty is low, taken when rsp_pop is high. rsp_is_last marks the final
// character of a number; NaN, infinity and magnitudes of 2^63 or more give a
// single beat with rsp_out_of_range set and a zero character.
// Each number leaves the queue and is converted (a 63-step integer
// double-dabble, run alongside the fraction scaling and rounding); the back
// end then emits a minus sign if the number is negative, scans past leading
// zeros and emits the integer digits, then the point and the fraction digits.
// An out-of-range input skips the conversion and gives its one beat. The
// character register can be refilled in the same cycle that its character is
// taken; a stalled receiver simply holds the back end.
// Reset empties the queue and the output register and returns the back end
// to idle; nothing else is kept between numbers.
module double_to_decimal_text #(
   parameter int FRAC_DIGITS = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [63:0] req_value_bits,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_char_code,
   output logic        rsp_is_last,
   output logic        rsp_out_of_range
);

   logic               q_push;
   logic               q_pop;
   logic               q_empty;
   d2dt_pkg::item_type f_item;
   d2dt_pkg::item_type b_item;

   d2dt_front u_front (
      .push       (req_push),
      .value_bits (req_value_bits),
      .q_full     (req_full),
      .q_push     (q_push),
      .q_item     (f_item)
   );

   d2dt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .item_in  (f_item),
      .full     (req_full),
      .pop      (q_pop),
      .item_out (b_item),
      .empty    (q_empty)
   );

   d2dt_back #(
      .FRAC_DIGITS (FRAC_DIGITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_item           (b_item),
      .q_pop            (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_char_code    (rsp_char_code),
      .rsp_is_last      (rsp_is_last),
      .rsp_out_of_range (rsp_out_of_range)
   );

endmodule

FILE: sim/tb.sv
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          FRAC_DIGITS = 6;
   localparam logic [63:0] FRAC_SCALE  = 64'd1000000;
   localparam int          STALL_LIMIT = 4000;

   typedef struct {
      logic [7:0] char_code;
      logic       is_last;
      logic       out_of_range;
   } text_beat_type;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [63:0] req_value_bits;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [7:0]  rsp_char_code;
   logic        rsp_is_last;
   logic        rsp_out_of_range;

   text_beat_type pending_text[$];
   int            fail_count;
   int            numbers_sent;
   int            chars_seen;
   int            range_errors_seen;
   int            stall_cycles;
   bit            no_idle;

   double_to_decimal_text #(.FRAC_DIGITS(FRAC_DIGITS)) u_top (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_value_bits(req_value_bits),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_char_code(rsp_char_code),
      .rsp_is_last(rsp_is_last), .rsp_out_of_range(rsp_out_of_range)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // floor of (f * 10^6 rounded to 53 significant bits) / 2^s
   function automatic logic [63:0] scale_fraction(logic [63:0] f, int s);
      logic [127:0] prod;
      logic [127:0] rem;
      logic [127:0] half;
      logic [63:0]  q;
      int           len;
      int           k;
      int           net;
      prod = {64'd0, f} * {64'd0, FRAC_SCALE};
      len = 0;
      for (int i = 0; i < 128; i++) if (prod[i]) len = i + 1;
      k = 0;
      q = prod[63:0];
      if (len > 53) begin
         k = len - 53;
         rem = prod & ((128'd1 << k) - 128'd1);
         half = 128'd1 << (k - 1);
         q = 64'(prod >> k);
         if (rem > half || (rem == half && q[0])) q = q + 64'd1;
      end
      net = s - k;
      if (net >= 64) return 64'd0;
      if (net >= 0) return q >> net;
      return q << (-net);
   endfunction

   task automatic add_char(logic [7:0] c, logic last);
      text_beat_type b;
      b.char_code = c;
      b.is_last = last;
      b.out_of_range = 1'b0;
      pending_text.push_back(b);
   endtask

   task automatic predict_text(logic [63:0] v);
      logic [10:0]   expo;
      logic [51:0]   mant;
      logic [63:0]   m;
      logic [63:0]   ip;
      logic [63:0]   fp;
      int            s;
      logic [7:0]    int_digits[$];
      logic [7:0]    frac_digits[FRAC_DIGITS];
      text_beat_type b;
      expo = v[62:52];
      mant = v[51:0];
      if (expo == d2dt_pkg::EXP_ALL_ONES || expo >= d2dt_pkg::EXP_LIMIT) begin
         b.char_code = d2dt_pkg::CHAR_NONE;
         b.is_last = 1'b1;
         b.out_of_range = 1'b1;
         pending_text.push_back(b);
         return;
      end
      if (expo == 11'd0) begin
         m = {12'd0, mant};
         s = 1074;
      end else begin
         m = {11'd0, 1'b1, mant};
         s = 1075 - int'(expo);
      end
      if (s <= 0) begin
         ip = m << (-s);
         fp = 64'd0;
      end else if (s >= 53) begin
         ip = 64'd0;
         fp = scale_fraction(m, s);
      end else begin
         ip = m >> s;
         fp = scale_fraction(m & ((64'd1 << s) - 64'd1), s);
      end
      if (fp >= FRAC_SCALE) fp = FRAC_SCALE - 64'd1;
      // negative zero carries no sign, other negatives do
      if (v[63] && (expo != 11'd0 || mant != 52'd0)) add_char(d2dt_pkg::CHAR_MINUS, 1'b0);
      do begin
         int_digits.push_front(d2dt_pkg::CHAR_ZERO + 8'(ip % 64'd10));
         ip = ip / 64'd10;
      end while (ip != 64'd0);
      foreach (int_digits[i]) add_char(int_digits[i], 1'b0);
      add_char(d2dt_pkg::CHAR_DOT, 1'b0);
      for (int i = FRAC_DIGITS - 1; i >= 0; i--) begin
         frac_digits[i] = d2dt_pkg::CHAR_ZERO + 8'(fp % 64'd10);
         fp = fp / 64'd10;
      end
      for (int i = 0; i < FRAC_DIGITS; i++) add_char(frac_digits[i], i == FRAC_DIGITS - 1);
   endtask

   // push stays high across back-to-back beats so it never gets two assignments in a step
   task automatic send_number(logic [63:0] v);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_value_bits <= v;
      do @(posedge clock); while (req_full);
      predict_text(v);
      numbers_sent++;
   endtask

   task automatic drain_results();
      req_push <= 1'b0;
      while (pending_text.size() != 0) @(posedge clock);
   endtask

   function automatic logic [63:0] random_number();
      logic [63:0] v;
      int          kind;
      v = {$urandom, $urandom};
      kind = $urandom_range(0, 9);
      unique case (kind)
         0, 1, 2, 3: v[62:52] = 11'($urandom_range(1023 - 25, 1085));
         4: v[62:52] = 11'($urandom_range(1023 - 60, 1022));
         5: v[62:52] = 11'($urandom_range(0, 4));
         6: begin
            v[62:52] = 11'($urandom_range(1023, 1045));
            v[31:0] = 32'd0;
         end
         7: v[62:52] = $urandom_range(0, 1) ? d2dt_pkg::EXP_ALL_ONES
                                            : 11'($urandom_range(1086, 2046));
         default: ;
      endcase
      return v;
   endfunction

   task automatic test_directed();
      logic [63:0] cases[$];
      cases = '{64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
                64'h3ff0_0000_0000_0000, 64'hbff0_0000_0000_0000,
                64'h3fe0_0000_0000_0000, 64'h3fb9_9999_9999_999a,
                64'h405e_dd2f_1a9f_be77, 64'h0000_0000_0000_0001,
                64'h000f_ffff_ffff_ffff, 64'h8000_0000_0000_0001,
                64'hbeb0_c6f7_a0b5_ed8d, 64'h43df_ffff_ffff_ffff,
                64'hc3df_ffff_ffff_ffff, 64'h43e0_0000_0000_0000,
                64'h7ff0_0000_0000_0000, 64'hfff0_0000_0000_0000,
                64'h7ff8_0000_0000_0001, 64'hffff_ffff_ffff_ffff,
                64'h7fef_ffff_ffff_ffff, 64'h3fef_ffff_ffff_ffff,
                64'h3eb0_c6f7_a0b5_ed8d, 64'h4330_0000_0000_0001,
                64'h432f_ffff_ffff_ffff, 64'h3feb_ffff_ffff_fffe};
      foreach (cases[i]) send_number(cases[i]);
   endtask

   task automatic test_random_mix(int count);
      repeat (count) send_number(random_number());
   endtask

   task automatic test_full_speed(int count);
      no_idle = 1'b1;
      repeat (count) send_number(random_number());
      no_idle = 1'b0;
   endtask

   task automatic test_drained_sender(int count);
      repeat (count) begin
         drain_results();
         send_number(random_number());
      end
   endtask

   // result side: random stall per beat unless no_idle is set, compare each beat with the oldest expected one
   initial begin
      text_beat_type want;
      int            stall;
      rsp_pop = 1'b0;
      @(negedge reset);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         chars_seen++;
         if (rsp_out_of_range) range_errors_seen++;
         if (pending_text.size() == 0) begin
            $error("unexpected beat: char_code %h", rsp_char_code);
            fail_count++;
         end else begin
            want = pending_text.pop_front();
            if (rsp_char_code !== want.char_code) begin
               $error("char_code: expected %h actual %h", want.char_code, rsp_char_code);
               fail_count++;
            end
            if (rsp_is_last !== want.is_last) begin
               $error("is_last: expected %b actual %b", want.is_last, rsp_is_last);
               fail_count++;
            end
            if (rsp_out_of_range !== want.out_of_range) begin
               $error("out_of_range: expected %b actual %b",
                      want.out_of_range, rsp_out_of_range);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("double_to_decimal_text verification failed");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_value_bits = 64'd0;
      no_idle = 1'b0;
      fail_count = 0;
      numbers_sent = 0;
      chars_seen = 0;
      range_errors_seen = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_mix(300);
      test_full_speed(60);
      test_drained_sender(20);
      test_random_mix(56);
      drain_results();
      repeat (300) @(posedge clock);
      $display("sent %0d numbers, checked %0d characters, %0d out-of-range results",
               numbers_sent, chars_seen, range_errors_seen);
      if (fail_count == 0) begin
         $display("double_to_decimal_text verification clean");
      end else begin
         $display("double_to_decimal_text verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
